// File: design/hidrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_pkg
// Shared types and constants of the HID report descriptor parser.
// ----------------------------------------------------------------------------
package hidrd_pkg;
    localparam int USAGE_SLOTS  = 16;
    localparam int EXPAND_SLOTS = 32;
    localparam int MAX_BUTTONS  = 32;
    localparam int USW = $clog2(USAGE_SLOTS);
    localparam int UCW = $clog2(USAGE_SLOTS + 1);
    localparam int EXW = $clog2(EXPAND_SLOTS + 1);

    localparam logic [7:0]  LONG_PREFIX = 8'hFE;
    localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
    localparam logic [15:0] PAGE_BUTTON  = 16'h0009;
    localparam logic [15:0] USAGE_X   = 16'h0030;
    localparam logic [15:0] USAGE_Y   = 16'h0031;
    localparam logic [15:0] USAGE_HAT = 16'h0039;
    localparam logic [20:0] PARK_POS = 21'h100000;
    localparam logic [20:0] POS_MAX  = 21'h1FFFFF;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // One complete item handed from the byte decoder to the executor.
    typedef struct packed {
        logic [7:0]  prefix;
        logic [31:0] value;
        logic        final_item;  // finish descriptor after this (prefix may be a no-op)
    } item_t;

    function automatic logic [2:0] data_len(input logic [7:0] p);
        data_len = (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
    endfunction

    function automatic logic [15:0] sat16(input logic [31:0] v);
        sat16 = (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
    endfunction
endpackage

// File: design/hid_report_descriptor_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser
// Walks a HID report descriptor and reports X, Y, hat and button layout.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid, in_stall, desc_byte, final_byte | byte stream in
//  out     | out_valid, out_stall, result fields       | four words per run
//
//  An Input item on the Generic Desktop page scans its usages in the
//  executor, one usage per cycle, at most 32 usages.
//  The last byte is followed by four result words, one a cycle when not stalled.
//  Reset clears all descriptor state; the usage slots need no clearing.
//  The two-entry queue lets the decoder keep taking bytes while a scan runs.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  desc_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  field_kind,
    output logic        present,
    output logic [19:0] bit_offset,
    output logic [15:0] field_size,
    output logic signed [31:0] logical_min,
    output logic signed [31:0] logical_max,
    output logic [7:0]  report_ident,
    output logic        layout_found,
    output logic        last_result
);
    import hidrd_pkg::*;

    // decoder to queue
    logic  fq_valid;
    item_t fq_item;
    logic  fq_full;
    // queue to executor
    logic  bq_valid;
    item_t bq_item;
    logic  bq_take;

    hidrd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .desc_byte  (desc_byte),
        .final_byte (final_byte),
        .q_valid    (fq_valid),
        .q_item     (fq_item),
        .q_full     (fq_full)
    );

    hidrd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fq_valid),
        .wr_item  (fq_item),
        .full     (fq_full),
        .rd_valid (bq_valid),
        .rd_item  (bq_item),
        .rd_en    (bq_take)
    );

    hidrd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (bq_valid),
        .q_item       (bq_item),
        .q_take       (bq_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_kind   (field_kind),
        .present      (present),
        .bit_offset   (bit_offset),
        .field_size   (field_size),
        .logical_min  (logical_min),
        .logical_max  (logical_max),
        .report_ident (report_ident),
        .layout_found (layout_found),
        .last_result  (last_result)
    );
endmodule

// File: design/hidrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_front
// Byte decoder: assembles short items, skips long items, marks the end.
// ----------------------------------------------------------------------------
module hidrd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         desc_byte,
    input  logic               final_byte,
    output logic               q_valid,
    output hidrd_pkg::item_t   q_item,
    input  logic               q_full
);
    import hidrd_pkg::*;

    typedef enum logic [2:0] {PH_PREFIX, PH_D1, PH_D2, PH_D3, PH_D4,
                              PH_LLEN, PH_LTAG, PH_LSKIP} phase_t;

    phase_t      phase_reg;
    logic [7:0]  prefix_reg;
    logic [31:0] value_reg;
    logic [8:0]  skip_reg;

    logic        take;
    logic [31:0] val_next;
    logic [1:0]  idx;
    logic        emit;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;
    assign idx      = 2'(phase_reg - PH_D1);

    always_comb
    begin
        val_next = value_reg | ({24'd0, desc_byte} << {idx, 3'd0});
        emit = 1'b0;
        q_item.prefix = prefix_reg;
        q_item.value = val_next;
        q_item.final_item = final_byte;
        unique case (phase_reg)
            PH_PREFIX:
            begin
                q_item.prefix = (desc_byte == LONG_PREFIX) ? 8'h04 : desc_byte;
                q_item.value = 32'd0;
                emit = final_byte || (desc_byte != LONG_PREFIX &&
                                      data_len(desc_byte) == 3'd0);
            end
            PH_D1, PH_D2, PH_D3, PH_D4:
                emit = final_byte || ({1'b0, idx} + 3'd1 >= data_len(prefix_reg));
            default:
            begin
                // long item bytes: a dummy reserved item carries the end mark
                q_item.prefix = 8'h0C;
                emit = final_byte;
            end
        endcase
    end

    assign q_valid = take && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            skip_reg  <= 9'd0;
        end
        else if (take)
        begin
            if (final_byte)
                phase_reg <= PH_PREFIX;
            else
            begin
                unique case (phase_reg)
                    PH_PREFIX:
                        if (desc_byte == LONG_PREFIX)
                            phase_reg <= PH_LLEN;
                        else if (data_len(desc_byte) != 3'd0)
                            phase_reg <= PH_D1;
                    PH_D1, PH_D2, PH_D3, PH_D4:
                        if ({1'b0, idx} + 3'd1 >= data_len(prefix_reg))
                            phase_reg <= PH_PREFIX;
                        else
                            phase_reg <= phase_t'(phase_reg + 3'd1);
                    PH_LLEN:
                    begin
                        skip_reg  <= {1'b0, desc_byte};
                        phase_reg <= PH_LTAG;
                    end
                    PH_LTAG:
                        phase_reg <= (skip_reg == 9'd0) ? PH_PREFIX : PH_LSKIP;
                    default:
                    begin
                        skip_reg <= skip_reg - 9'd1;
                        if (skip_reg <= 9'd1)
                            phase_reg <= PH_PREFIX;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (phase_reg == PH_PREFIX)
            begin
                prefix_reg <= desc_byte;
                value_reg  <= 32'd0;
            end
            else
                value_reg <= val_next;
        end
    end
endmodule

// File: design/hidrd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_fifo
// Two-entry item queue between decoder and executor.
// ----------------------------------------------------------------------------
module hidrd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  hidrd_pkg::item_t wr_item,
    output logic             full,
    output logic             rd_valid,
    output hidrd_pkg::item_t rd_item,
    input  logic             rd_en
);
    import hidrd_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= !wp_reg;
            if (rd_en)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_valid |-> !rd_en) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("count mismatch");
`endif
endmodule

// File: design/hidrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidrd_back
// Item executor: keeps descriptor state, scans usages, emits four results.
// ----------------------------------------------------------------------------
module hidrd_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  hidrd_pkg::item_t q_item,
    output logic             q_take,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       field_kind,
    output logic             present,
    output logic [19:0]      bit_offset,
    output logic [15:0]      field_size,
    output logic signed [31:0] logical_min,
    output logic signed [31:0] logical_max,
    output logic [7:0]       report_ident,
    output logic             layout_found,
    output logic             last_result
);
    import hidrd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t      state_reg;
    logic [20:0] pos_reg;
    logic [15:0] page_reg;
    logic [31:0] lmin_reg, lmax_reg;
    logic [15:0] rsize_reg, rcount_reg;
    logic [15:0] ulist_reg [USAGE_SLOTS];
    logic [UCW-1:0] ucnt_reg;
    logic [31:0] umin_reg, umax_reg;
    logic [2:0]  cpres_reg;
    logic [19:0] cbit_reg [3];
    logic [15:0] csize_reg [3];
    logic [31:0] clo_reg [3], chi_reg [3];
    logic        bpres_reg;
    logic [20:0] bbit_reg;
    logic [5:0]  bcnt_reg;
    logic [7:0]  rid_reg;
    logic        found_reg;
    logic        fin_reg;
    logic [EXW-1:0] k_reg, n_reg;
    logic        expand_reg;
    logic [36:0] off_reg;     // running offset of usage k
    logic [1:0]  emit_reg;
    logic        ov_reg;
    logic [1:0]  kind_reg;
    logic        pres_o_reg, found_o_reg, last_o_reg;
    logic [19:0] bit_o_reg;
    logic [15:0] size_o_reg;
    logic [31:0] lo_o_reg, hi_o_reg;
    logic [7:0]  rid_o_reg;

    // decoded item
    logic [2:0]  sz;
    logic [1:0]  ityp;
    logic [3:0]  tag;
    logic [31:0] v, sv;
    logic        main_input;
    logic [36:0] prod;
    logic [36:0] np;
    logic        out_free;

    assign sz   = data_len(q_item.prefix);
    assign ityp = q_item.prefix[3:2];
    assign tag  = q_item.prefix[7:4];
    assign v    = q_item.value;
    always_comb
    begin
        unique case (sz)
            3'd1:    sv = {{24{v[7]}}, v[7:0]};
            3'd2:    sv = {{16{v[15]}}, v[15:0]};
            default: sv = v;
        endcase
    end
    assign main_input = (ityp == TYPE_MAIN) && (tag == 4'd8);
    assign prod = {5'd0, 32'(rsize_reg) * 32'(rcount_reg)};
    assign np   = {16'd0, pos_reg} + prod;
    assign out_free = !ov_reg || !out_stall;
    assign q_take = (state_reg == ST_IDLE) && q_valid;

    // usage under scan
    logic [15:0] cur_u;
    logic [31:0] expu;
    logic [1:0]  which;
    logic        hit;
    logic [32:0] btn_sum;
    always_comb
    begin
        expu  = umin_reg + {{(32-EXW){1'b0}}, k_reg};
        cur_u = expand_reg ? expu[15:0] : ulist_reg[k_reg[USW-1:0]];
        hit   = 1'b1;
        which = 2'd0;
        priority if (cur_u == USAGE_X) which = 2'd0;
        else if (cur_u == USAGE_Y)     which = 2'd1;
        else if (cur_u == USAGE_HAT)   which = 2'd2;
        else hit = 1'b0;
        btn_sum = {12'd0, bbit_reg} + {27'd0, bcnt_reg};
    end

    logic [32:0] span;  // umax - umin + 1 as signed when umax >= umin
    logic signed [33:0] diff;
    logic [EXW-1:0] nexp;
    always_comb
    begin
        diff = $signed({2'b0, umax_reg}) - $signed({2'b0, umin_reg});
        if (umax_reg[31])
            diff = $signed({2'b11, umax_reg}) - $signed({2'b0, umin_reg});
        span = 33'd0;
        if (!diff[33])
            span = diff[32:0] + 33'd1;
        nexp = (span > 33'(EXPAND_SLOTS)) ? EXW'(EXPAND_SLOTS) : EXW'(span);
    end

    logic [EXW-1:0] nplain;
    assign nplain = (32'(ucnt_reg) > 32'(EXPAND_SLOTS)) ? EXW'(EXPAND_SLOTS)
                                                        : EXW'(ucnt_reg);

    logic [5:0] rc_cl;
    assign rc_cl = (rcount_reg > 16'(MAX_BUTTONS)) ? 6'(MAX_BUTTONS) : 6'(rcount_reg);
    logic [16:0] bsum;
    assign bsum = {11'd0, bcnt_reg} + {1'b0, rcount_reg};

    task automatic clear_local;
    begin
        ucnt_reg <= '0;
        umin_reg <= '1;
        umax_reg <= '1;
    end
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg <= '0; page_reg <= '0; lmin_reg <= '0; lmax_reg <= '0;
            rsize_reg <= '0; rcount_reg <= '0;
            ucnt_reg <= '0; umin_reg <= '1; umax_reg <= '1;
            cpres_reg <= '0; bpres_reg <= 1'b0; bbit_reg <= '0; bcnt_reg <= '0;
            rid_reg <= '0; found_reg <= 1'b0; fin_reg <= 1'b0;
            k_reg <= '0; n_reg <= '0; expand_reg <= 1'b0; off_reg <= '0;
            emit_reg <= '0; ov_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cbit_reg[i] <= '0; csize_reg[i] <= '0;
                clo_reg[i] <= '0; chi_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_EMIT && out_free)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                if (q_valid)
                begin
                    fin_reg <= q_item.final_item;
                    if (ityp == TYPE_GLOBAL)
                    begin
                        unique case (tag)
                            4'd0: page_reg <= v[15:0];
                            4'd1: lmin_reg <= sv;
                            4'd2: lmax_reg <= sv;
                            4'd7: rsize_reg <= sat16(v);
                            4'd8:
                                if (rid_reg == 8'd0 && !found_reg)
                                begin
                                    rid_reg <= v[7:0];
                                    pos_reg <= 21'd8;
                                end
                                else if (v[7:0] != rid_reg)
                                    pos_reg <= PARK_POS;
                            4'd9: rcount_reg <= sat16(v);
                            default: ;
                        endcase
                    end
                    else if (ityp == TYPE_LOCAL)
                    begin
                        if (tag == 4'd0 && 32'(ucnt_reg) < 32'(USAGE_SLOTS))
                        begin
                            ulist_reg[ucnt_reg[USW-1:0]] <= v[15:0];
                            ucnt_reg <= ucnt_reg + UCW'(1);
                        end
                        else if (tag == 4'd1)
                            umin_reg <= v;
                        else if (tag == 4'd2)
                            umax_reg <= v;
                    end

                    if (main_input && !v[0] && pos_reg < PARK_POS
                        && page_reg == PAGE_DESKTOP)
                    begin
                        // scan usages one per cycle
                        expand_reg <= (ucnt_reg == '0) && !umin_reg[31];
                        n_reg <= ((ucnt_reg == '0) && !umin_reg[31]) ? nexp : nplain;
                        k_reg <= '0;
                        off_reg <= {16'd0, pos_reg};
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        if (main_input)
                        begin
                            if (!v[0] && pos_reg < PARK_POS && page_reg == PAGE_BUTTON)
                            begin
                                found_reg <= 1'b1;
                                if (!bpres_reg)
                                begin
                                    bpres_reg <= 1'b1;
                                    bbit_reg  <= pos_reg;
                                    bcnt_reg  <= rc_cl;
                                end
                                else if (rsize_reg == 16'd1 &&
                                         btn_sum == {12'd0, pos_reg})
                                    bcnt_reg <= (bsum > 17'(MAX_BUTTONS))
                                              ? 6'(MAX_BUTTONS) : bsum[5:0];
                            end
                            pos_reg <= (np > {16'd0, POS_MAX}) ? POS_MAX : np[20:0];
                        end
                        if (ityp == TYPE_MAIN)
                            clear_local();
                        if (q_item.final_item)
                        begin
                            emit_reg <= 2'd0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (k_reg < n_reg && 32'(k_reg) < 32'(rcount_reg))
                    begin
                        if (hit && !cpres_reg[which] && off_reg < {16'd0, PARK_POS})
                        begin
                            cpres_reg[which] <= 1'b1;
                            cbit_reg[which]  <= off_reg[19:0];
                            csize_reg[which] <= rsize_reg;
                            clo_reg[which]   <= lmin_reg;
                            chi_reg[which]   <= lmax_reg;
                            found_reg <= 1'b1;
                        end
                        off_reg <= off_reg + {21'd0, rsize_reg};
                        k_reg <= k_reg + EXW'(1);
                    end
                    else
                    begin
                        pos_reg <= (np > {16'd0, POS_MAX}) ? POS_MAX : np[20:0];
                        clear_local();
                        if (fin_reg)
                        begin
                            emit_reg <= 2'd0;
                            state_reg <= ST_EMIT;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                if (out_free)
                begin
                    emit_reg <= emit_reg + 2'd1;
                    if (emit_reg == 2'd3)
                    begin
                        state_reg <= ST_IDLE;
                        pos_reg <= '0; page_reg <= '0; lmin_reg <= '0; lmax_reg <= '0;
                        rsize_reg <= '0; rcount_reg <= '0;
                        clear_local();
                        cpres_reg <= '0; bpres_reg <= 1'b0; bbit_reg <= '0;
                        bcnt_reg <= '0; rid_reg <= '0; found_reg <= 1'b0;
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            kind_reg    <= emit_reg;
            rid_o_reg   <= rid_reg;
            found_o_reg <= found_reg;
            last_o_reg  <= (emit_reg == 2'd3);
            if (emit_reg == 2'd3)
            begin
                pres_o_reg <= bpres_reg;
                bit_o_reg  <= bpres_reg ? bbit_reg[19:0] : 20'd0;
                size_o_reg <= bpres_reg ? {10'd0, bcnt_reg} : 16'd0;
                lo_o_reg   <= '0;
                hi_o_reg   <= '0;
            end
            else
            begin
                pres_o_reg <= cpres_reg[emit_reg];
                bit_o_reg  <= cpres_reg[emit_reg] ? cbit_reg[emit_reg] : '0;
                size_o_reg <= cpres_reg[emit_reg] ? csize_reg[emit_reg] : '0;
                lo_o_reg   <= cpres_reg[emit_reg] ? clo_reg[emit_reg] : '0;
                hi_o_reg   <= cpres_reg[emit_reg] ? chi_reg[emit_reg] : '0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign field_kind   = kind_reg;
    assign present      = pres_o_reg;
    assign bit_offset   = bit_o_reg;
    assign field_size   = size_o_reg;
    assign logical_min  = lo_o_reg;
    assign logical_max  = hi_o_reg;
    assign report_ident = rid_o_reg;
    assign layout_found = found_o_reg;
    assign last_result  = last_o_reg;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == ST_IDLE) else $error("take outside idle");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> k_reg <= n_reg) else $error("scan overrun");
    a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= 6'(MAX_BUTTONS)) else $error("button count over cap");
`endif
endmodule
